// ===== hdl/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and codes for the bounded deque: commands, result status,
// cell operations and the controller state.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned CmdW    = 3;
  localparam int unsigned StatusW = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_DISPLAY    = 3'd4
  } cmd_t;

  localparam logic [StatusW-1:0] STATUS_OK    = 2'd0;
  localparam logic [StatusW-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [StatusW-1:0] STATUS_FULL  = 2'd2;

  // Shift right inserts at the front, shift left drops the front,
  // rotate turns the occupied cells by one towards the front.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SHIFT_R,
    OP_PUSH_BACK,
    OP_SHIFT_L,
    OP_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t                 op;
    logic signed [DataW-1:0]  value;
  } cell_ctl_t;

  typedef enum logic {
    ST_RUN,
    ST_SHOW
  } state_t;

endpackage : bdq_pkg

`default_nettype wire

// ===== hdl/bdq_cell.sv =====
// ----------------------------------------------------------------------------
// bdq_cell
// One element slot of the deque chain. Takes its neighbour's value on a
// shift, the pushed value at the tail, or the head value on a rotate wrap.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 7
) (
  input  wire                                 clk,
  input  bdq_pkg::cell_ctl_t                  ctl,
  input  wire  [CW-1:0]                       count,
  input  wire  signed [bdq_pkg::DataW-1:0]    prev_data,
  input  wire  signed [bdq_pkg::DataW-1:0]    next_data,
  input  wire  signed [bdq_pkg::DataW-1:0]    head_data,
  output logic signed [bdq_pkg::DataW-1:0]    data
);
  import bdq_pkg::*;

  logic signed [DataW-1:0] data_r;
  logic signed [DataW-1:0] data_nxt;
  logic                    at_tail;
  logic                    is_last;

  assign at_tail = (count == CW'(IDX));
  assign is_last = (count == CW'(IDX + 1));

  always_comb begin
    data_nxt = data_r;
    unique case (ctl.op)
      OP_HOLD:      data_nxt = data_r;
      OP_SHIFT_R:   data_nxt = prev_data;
      OP_PUSH_BACK: data_nxt = at_tail ? ctl.value : data_r;
      OP_SHIFT_L:   data_nxt = next_data;
      OP_ROTATE:    data_nxt = is_last ? head_data : next_data;
      default:      data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule : bdq_cell

`default_nettype wire

// ===== hdl/bdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bdq_ctrl
// Command decode, element count, display sequencing and the result
// register that parts the input side from the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_ctrl #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned CW    = 7
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire  [bdq_pkg::CmdW-1:0]            in_cmd,
  input  wire  signed [bdq_pkg::DataW-1:0]    in_value,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic signed [bdq_pkg::DataW-1:0]    out_data,
  output logic [bdq_pkg::StatusW-1:0]         out_status,
  output logic                                out_last,
  input  wire  signed [bdq_pkg::DataW-1:0]    head_data,
  output bdq_pkg::cell_ctl_t                  cell_ctl,
  output logic [CW-1:0]                       count
);
  import bdq_pkg::*;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [CW-1:0]           left_r, left_nxt;
  logic                    out_valid_r;
  logic signed [DataW-1:0] out_data_r;
  logic [StatusW-1:0]      out_status_r;
  logic                    out_last_r;

  logic                    out_free;
  logic                    accept;
  logic                    is_full;
  logic                    is_empty;
  logic                    show_step;
  logic                    emit;
  logic signed [DataW-1:0] emit_data;
  logic [StatusW-1:0]      emit_status;
  logic                    emit_last;
  cmd_t                    cmd;

  assign cmd       = cmd_t'(in_cmd);
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_RUN) && out_free;
  assign accept    = in_valid && in_ready;
  assign is_full   = (count_r == CW'(DEPTH));
  assign is_empty  = (count_r == '0);
  assign show_step = (state_r == ST_SHOW) && out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_RUN: begin
        if (accept && cmd == CMD_DISPLAY && !is_empty) begin
          state_nxt = ST_SHOW;
        end
      end
      ST_SHOW: begin
        if (show_step && left_r == CW'(1)) begin
          state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_comb begin
    emit         = 1'b0;
    emit_data    = '0;
    emit_status  = STATUS_OK;
    emit_last    = 1'b1;
    cell_ctl.op    = OP_HOLD;
    cell_ctl.value = in_value;
    count_nxt    = count_r;
    left_nxt     = left_r;
    unique case (state_r)
      ST_RUN: begin
        if (accept) begin
          unique case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              emit = 1'b1;
              if (is_full) begin
                emit_status = STATUS_FULL;
              end else begin
                cell_ctl.op = (cmd == CMD_PUSH_FRONT) ? OP_SHIFT_R : OP_PUSH_BACK;
                count_nxt   = count_r + CW'(1);
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              emit = 1'b1;
              if (is_empty) begin
                emit_status = STATUS_EMPTY;
              end else begin
                cell_ctl.op = (cmd == CMD_POP_FRONT) ? OP_SHIFT_L : OP_HOLD;
                count_nxt   = count_r - CW'(1);
              end
            end
            CMD_DISPLAY: begin
              if (is_empty) begin
                emit        = 1'b1;
                emit_status = STATUS_EMPTY;
              end else begin
                left_nxt = count_r;
              end
            end
            default: emit = 1'b0;
          endcase
        end
      end
      ST_SHOW: begin
        if (show_step) begin
          emit        = 1'b1;
          emit_data   = head_data;
          emit_last   = (left_r == CW'(1));
          cell_ctl.op = OP_ROTATE;
          left_nxt    = left_r - CW'(1);
        end
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      count_r     <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      left_r  <= left_nxt;
      if (out_free) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit) begin
      out_data_r   <= emit_data;
      out_status_r <= emit_status;
      out_last_r   <= emit_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;
  assign count      = count_r;

endmodule : bdq_ctrl

`default_nettype wire

// ===== hdl/bounded_deque_unit.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_unit
// Bounded double-ended queue of signed 32-bit values held in a chain of
// cells, front element in the first cell.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  in      | in_valid in_ready in_cmd in_value       | beat in
//  out     | out_valid out_ready out_data            | beat out
//          | out_status out_last                     |
//
// A push or pop gives its result in the cycle after acceptance; the next beat
// can be taken in the same cycle that result is taken.
// A display streams one element per cycle from the first cell, unless the
// output stalls, while the occupied cells rotate by one; after count steps
// the order is restored. Input is held off for the length of a display.
// Reset clears the count and control; cell contents are left as they are.
// A stalled output beat holds; the block waits for the slot to free.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_deque_unit #(
  parameter int unsigned DEPTH = 64
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire  [bdq_pkg::CmdW-1:0]            in_cmd,
  input  wire  signed [bdq_pkg::DataW-1:0]    in_value,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic signed [bdq_pkg::DataW-1:0]    out_data,
  output logic [bdq_pkg::StatusW-1:0]         out_status,
  output logic                                out_last
);
  import bdq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  cell_ctl_t               cell_ctl;
  logic [CW-1:0]           count;
  logic signed [DataW-1:0] cell_data [DEPTH];

  bdq_ctrl #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_cmd     (in_cmd),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .out_status (out_status),
    .out_last   (out_last),
    .head_data  (cell_data[0]),
    .cell_ctl   (cell_ctl),
    .count      (count)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    bdq_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .ctl       (cell_ctl),
      .count     (count),
      .prev_data ((i == 0) ? cell_ctl.value : cell_data[(i == 0) ? 0 : i - 1]),
      .next_data (cell_data[(i + 1) % DEPTH]),
      .head_data (cell_data[0]),
      .data      (cell_data[i])
    );
  end

endmodule : bounded_deque_unit

`default_nettype wire

// ===== hdl/bdq_chk.sv =====
// ----------------------------------------------------------------------------
// bdq_chk
// Port-level checks on the deque: result beats, status codes and the
// hold-off of input during a display stream.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_chk (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_valid,
  input wire                              in_ready,
  input wire [bdq_pkg::CmdW-1:0]          in_cmd,
  input wire                              out_valid,
  input wire                              out_ready,
  input wire [bdq_pkg::DataW-1:0]         out_data,
  input wire [bdq_pkg::StatusW-1:0]       out_status,
  input wire                              out_last
);
  import bdq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)
      && $stable(out_status) && $stable(out_last))
    else $error("output beat changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STATUS_OK || out_status == STATUS_EMPTY
      || out_status == STATUS_FULL))
    else $error("undefined status code");

  a_error_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STATUS_OK |-> out_last && out_data == '0)
    else $error("error beat not single or carries data");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd == CMD_PUSH_FRONT || in_cmd == CMD_PUSH_BACK
      || in_cmd == CMD_POP_FRONT || in_cmd == CMD_POP_BACK) |=> out_valid && out_last)
    else $error("push or pop did not give its result");

  a_stream_holdoff: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input taken in the middle of a display");

endmodule : bdq_chk

bind bounded_deque_unit bdq_chk u_bdq_chk (.*);

`default_nettype wire
